>>> design/fpr_pkg.sv
// Shared types, constants and the CRC-8 update for the framed packet receiver.
// Depends on nothing; the top and the receiver core refer to it by scoped names.
package fpr_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int ADDR_W        = 5;
  localparam int COUNT_W       = 6;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic CFG_START_MARKER = 1'b0;
  localparam logic CFG_MAX_PAYLOAD  = 1'b1;

  localparam logic [7:0]         START_MARKER_RST = 8'd213;
  localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RST  = 6'd32;
  localparam logic [COUNT_W-1:0] DEPTH_LIMIT      = COUNT_W'(PAYLOAD_DEPTH);
  localparam logic [7:0]         CRC_POLY         = 8'h8C;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC     = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_NOISE  = 2'd1,
    FAULT_LENGTH = 2'd2,
    FAULT_CRC    = 2'd3
  } fault_t;

  typedef struct packed {
    phase_t             phase;
    fault_t             fault;
    logic [COUNT_W-1:0] count;
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_port_t;

  function automatic logic [7:0] crc8_maxim(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> design/framed_packet_receiver_crc8_top.sv
// Top level of the framed packet receiver: input register, receiver core,
// payload store and result register. Depends on fpr_pkg, fpr_rx_core and fpr_ram.
//
// The block takes one item per clock cycle while the result side is not stalled and
// returns one result per item. An item waits in the input register, the receiver
// core updates its state and the CRC in that cycle, and the result register holds
// the status after the item. The payload store is a RAM with a registered read port,
// so a stored byte read by an item appears together with that item's result. While a
// result is stalled, one further item can still be accepted into the input register.
module framed_packet_receiver_crc8_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_data_byte,
  input  logic [fpr_pkg::ADDR_W-1:0]  in_read_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_rx_phase,
  output logic [1:0]                  out_fault_code,
  output logic                        out_packet_finished,
  output logic [fpr_pkg::COUNT_W-1:0] out_payload_count,
  output logic [7:0]                  out_read_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [7:0]                  cfg_data
);

  logic                        in_valid_r;
  logic [1:0]                  kind_r;
  logic [7:0]                  data_r;
  logic [fpr_pkg::ADDR_W-1:0]  idx_r;
  logic                        out_valid_r;
  fpr_pkg::status_t            status_r;
  fpr_pkg::status_t            status_nxt;
  logic                        rd_sel_r;
  logic [7:0]                  start_marker_r;
  logic [fpr_pkg::COUNT_W-1:0] max_payload_r;
  fpr_pkg::wr_port_t           wr;
  logic [7:0]                  rd_data;
  logic                        advance;
  logic                        step;

  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= fpr_pkg::START_MARKER_RST;
      max_payload_r  <= fpr_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpr_pkg::CFG_START_MARKER: start_marker_r <= cfg_data;
        fpr_pkg::CFG_MAX_PAYLOAD:  max_payload_r  <= cfg_data[fpr_pkg::COUNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      data_r <= in_data_byte;
      idx_r  <= in_read_index;
    end
  end

  fpr_rx_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .kind         (kind_r),
    .data_byte    (data_r),
    .start_marker (start_marker_r),
    .max_payload  (max_payload_r),
    .status_nxt   (status_nxt),
    .wr           (wr)
  );

  fpr_ram #(
    .WIDTH (8),
    .DEPTH (fpr_pkg::PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (step && (kind_r == fpr_pkg::KIND_READ)),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status_r <= status_nxt;
      rd_sel_r <= (kind_r == fpr_pkg::KIND_READ);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rx_phase        = status_r.phase;
  assign out_fault_code      = status_r.fault;
  assign out_packet_finished = (status_r.phase == fpr_pkg::PH_DONE);
  assign out_payload_count   = status_r.count;
  assign out_read_value      = rd_sel_r ? rd_data : 8'd0;

  a_fault_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault_code != fpr_pkg::FAULT_NONE) |-> out_packet_finished)
    else $error("fault reported without a finished packet");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload_count <= fpr_pkg::DEPTH_LIMIT))
    else $error("payload count beyond store depth");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result side is free");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_rx_phase, out_fault_code,
                                                      out_payload_count, out_read_value}))
    else $error("stalled result changed before it was taken");

endmodule

>>> design/fpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/fpr_rx_core.sv
// Receiver state machine: phase, fault, CRC, count and announced length.
// Depends on fpr_pkg; drives the payload store write port.
module fpr_rx_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    data_byte,
  input  logic [7:0]                    start_marker,
  input  logic [fpr_pkg::COUNT_W-1:0]   max_payload,
  output fpr_pkg::status_t              status_nxt,
  output fpr_pkg::wr_port_t             wr
);

  fpr_pkg::phase_t             phase_r, phase_nxt;
  fpr_pkg::fault_t             fault_r, fault_nxt;
  logic [7:0]                  crc_r, crc_nxt;
  logic [fpr_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [fpr_pkg::COUNT_W-1:0] alen_r, alen_nxt;
  logic [fpr_pkg::COUNT_W-1:0] limit;
  logic                        store_ok;

  assign limit    = (max_payload < fpr_pkg::DEPTH_LIMIT) ? max_payload : fpr_pkg::DEPTH_LIMIT;
  assign store_ok = (count_r < fpr_pkg::DEPTH_LIMIT);

  always_comb begin
    phase_nxt = phase_r;
    fault_nxt = fault_r;
    crc_nxt   = crc_r;
    count_nxt = count_r;
    alen_nxt  = alen_r;
    unique case (kind)
      fpr_pkg::KIND_BYTE: begin
        unique case (phase_r)
          fpr_pkg::PH_START: begin
            if (data_byte == start_marker) begin
              phase_nxt = fpr_pkg::PH_LEN;
            end else begin
              phase_nxt = fpr_pkg::PH_DONE;
              fault_nxt = fpr_pkg::FAULT_NOISE;
            end
          end
          fpr_pkg::PH_LEN: begin
            if (data_byte <= {2'b00, limit}) begin
              alen_nxt  = data_byte[fpr_pkg::COUNT_W-1:0];
              phase_nxt = (data_byte == 8'd0) ? fpr_pkg::PH_CRC : fpr_pkg::PH_PAYLOAD;
            end else begin
              phase_nxt = fpr_pkg::PH_DONE;
              fault_nxt = fpr_pkg::FAULT_LENGTH;
            end
          end
          fpr_pkg::PH_PAYLOAD: begin
            if (store_ok) begin
              crc_nxt   = fpr_pkg::crc8_maxim(crc_r, data_byte);
              count_nxt = count_r + 1'b1;
            end
            if (count_nxt >= alen_r) begin
              phase_nxt = fpr_pkg::PH_CRC;
            end
          end
          fpr_pkg::PH_CRC: begin
            phase_nxt = fpr_pkg::PH_DONE;
            if (crc_r != data_byte) begin
              fault_nxt = fpr_pkg::FAULT_CRC;
            end
          end
          default: begin
          end
        endcase
      end
      fpr_pkg::KIND_CLEAR: begin
        phase_nxt = fpr_pkg::PH_START;
        fault_nxt = fpr_pkg::FAULT_NONE;
        crc_nxt   = 8'd0;
        count_nxt = '0;
        alen_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_nxt.phase = phase_nxt;
    status_nxt.fault = fault_nxt;
    status_nxt.count = count_nxt;
    wr.we   = step && (kind == fpr_pkg::KIND_BYTE) && (phase_r == fpr_pkg::PH_PAYLOAD) && store_ok;
    wr.addr = count_r[fpr_pkg::ADDR_W-1:0];
    wr.data = data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fpr_pkg::PH_START;
      fault_r <= fpr_pkg::FAULT_NONE;
      crc_r   <= 8'd0;
      count_r <= '0;
      alen_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fault_r <= fault_nxt;
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      alen_r  <= alen_nxt;
    end
  end

endmodule

>>> verif/fpr_checker.sv
`timescale 1ns / 1ps
// Checker for the framed packet receiver, with a small package of item types and a
// CRC-8 helper shared with the stimulus. Depends on fpr_pkg for phases, faults and codes.
package fpr_tb_pkg;

  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [4:0] idx;
  } rx_item_t;

  function automatic logic [7:0] maxim_crc_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 8'h8C) : (r >> 1);
    end
    return r;
  endfunction

endpackage

module fpr_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_data_byte,
  input  logic [fpr_pkg::ADDR_W-1:0]  in_read_index,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [2:0]                  out_rx_phase,
  input  logic [1:0]                  out_fault_code,
  input  logic                        out_packet_finished,
  input  logic [fpr_pkg::COUNT_W-1:0] out_payload_count,
  input  logic [7:0]                  out_read_value,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [7:0]                  cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          results_seen
);
  import fpr_pkg::*;
  import fpr_tb_pkg::*;

  typedef struct packed {
    phase_t             phase;
    fault_t             fault;
    logic               finished;
    logic [COUNT_W-1:0] count;
    logic [7:0]         value;
  } rx_status_t;

  rx_status_t         status_q[$];
  phase_t             phase_m;
  fault_t             fault_m;
  logic [7:0]         crc_m;
  logic [COUNT_W-1:0] count_m;
  logic [COUNT_W-1:0] length_m;
  logic [7:0]         store_m [PAYLOAD_DEPTH];
  logic [7:0]         marker_m;
  logic [COUNT_W-1:0] max_m;

  task automatic log_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic clear_frame();
    phase_m  = PH_START;
    fault_m  = FAULT_NONE;
    crc_m    = 8'd0;
    count_m  = '0;
    length_m = '0;
  endtask

  task automatic abort_frame(input fault_t code);
    fault_m = code;
    phase_m = PH_DONE;
  endtask

  task automatic take_line_byte(input logic [7:0] b);
    logic [COUNT_W-1:0] lim;
    lim = (max_m < DEPTH_LIMIT) ? max_m : DEPTH_LIMIT;
    case (phase_m)
      PH_START: begin
        if (b == marker_m) phase_m = PH_LEN;
        else abort_frame(FAULT_NOISE);
      end
      PH_LEN: begin
        if ({2'b00, lim} >= b) begin
          length_m = b[COUNT_W-1:0];
          phase_m  = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end else begin
          abort_frame(FAULT_LENGTH);
        end
      end
      PH_PAYLOAD: begin
        if (count_m < DEPTH_LIMIT) begin
          crc_m = maxim_crc_next(crc_m, b);
          store_m[count_m[ADDR_W-1:0]] = b;
          count_m++;
        end
        if (count_m >= length_m) phase_m = PH_CRC;
      end
      PH_CRC: begin
        if (crc_m == b) phase_m = PH_DONE;
        else abort_frame(FAULT_CRC);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : monitor
    rx_status_t want;
    if (!rst_n) begin
      clear_frame();
      marker_m = START_MARKER_RST;
      max_m    = MAX_PAYLOAD_RST;
      foreach (store_m[i]) store_m[i] = 8'd0;
      status_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (status_q.size() == 0) begin
          log_mismatch($sformatf("result with none outstanding, rx_phase %0d", out_rx_phase));
        end else begin
          want = status_q.pop_front();
          if (out_rx_phase != want.phase)
            log_mismatch($sformatf("rx_phase %0d, expected %0d", out_rx_phase, want.phase));
          if (out_fault_code != want.fault)
            log_mismatch($sformatf("fault_code %0d, expected %0d", out_fault_code, want.fault));
          if (out_packet_finished != want.finished)
            log_mismatch($sformatf("packet_finished %0d, expected %0d",
                                   out_packet_finished, want.finished));
          if (out_payload_count != want.count)
            log_mismatch($sformatf("payload_count %0d, expected %0d",
                                   out_payload_count, want.count));
          if (out_read_value != want.value)
            log_mismatch($sformatf("read_value 0x%02h, expected 0x%02h",
                                   out_read_value, want.value));
        end
      end
      if (in_valid && in_ready) begin
        want.value = 8'd0;
        case (in_kind)
          KIND_BYTE:  take_line_byte(in_data_byte);
          KIND_CLEAR: clear_frame();
          KIND_READ:  want.value = store_m[in_read_index];
          default: begin
          end
        endcase
        want.phase    = phase_m;
        want.fault    = fault_m;
        want.finished = (phase_m == PH_DONE);
        want.count    = count_m;
        status_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START_MARKER) marker_m = cfg_data;
        else max_m = cfg_data[COUNT_W-1:0];
      end
    end
    pending = status_q.size();
  end

endmodule

>>> verif/framed_packet_receiver_crc8_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the framed packet receiver: clock, reset, framed and broken packet
// stimulus, receiver stalls and the verdict. Depends on fpr_pkg, fpr_tb_pkg and fpr_checker.
module framed_packet_receiver_crc8_top_test;
  import fpr_pkg::*;
  import fpr_tb_pkg::*;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [1:0]          in_kind       = KIND_BYTE;
  logic [7:0]          in_data_byte  = 8'd0;
  logic [ADDR_W-1:0]   in_read_index = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [2:0]          out_rx_phase;
  logic [1:0]          out_fault_code;
  logic                out_packet_finished;
  logic [COUNT_W-1:0]  out_payload_count;
  logic [7:0]          out_read_value;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic                cfg_index     = CFG_START_MARKER;
  logic [7:0]          cfg_data      = 8'd0;

  int fail_count;
  int pending;
  int results_seen;

  rx_item_t   line_q[$];
  bit         written [PAYLOAD_DEPTH];
  int         written_list[$];
  logic [7:0] cur_marker = START_MARKER_RST;
  int         cur_limit = PAYLOAD_DEPTH;
  int         items_made;
  int         frames_made;
  int         settings_done;
  int         burst_left;
  int         gap_left;
  int         hold_cnt;
  int         next_hold_at = 300;
  int         ready_mode;
  int         mode_left;

  framed_packet_receiver_crc8_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_data_byte        (in_data_byte),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rx_phase        (out_rx_phase),
    .out_fault_code      (out_fault_code),
    .out_packet_finished (out_packet_finished),
    .out_payload_count   (out_payload_count),
    .out_read_value      (out_read_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  fpr_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_data_byte        (in_data_byte),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rx_phase        (out_rx_phase),
    .out_fault_code      (out_fault_code),
    .out_packet_finished (out_packet_finished),
    .out_payload_count   (out_payload_count),
    .out_read_value      (out_read_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending),
    .results_seen        (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : sender
    rx_item_t head;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (in_valid && !in_ready) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (line_q.size() > 0) begin
      head = line_q.pop_front();
      in_valid      <= 1'b1;
      in_kind       <= head.kind;
      in_data_byte  <= head.data;
      in_read_index <= head.idx;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 48);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: changing stall modes, plus a long hold-off now and then so the block fills up.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
      mode_left <= 0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (results_seen >= next_hold_at) begin
      out_ready    <= 1'b0;
      hold_cnt     <= 80;
      next_hold_at <= next_hold_at + 600;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(5, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic [4:0] idx);
    line_q.push_back('{kind: kind, data: data, idx: idx});
    items_made++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(KIND_BYTE, b, 5'($urandom_range(0, 31)));
  endtask

  task automatic push_read();
    if (written_list.size() == 0) begin
      push_item(KIND_NOP, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
    end else begin
      push_item(KIND_READ, 8'($urandom_range(0, 255)),
                5'(written_list[$urandom_range(0, written_list.size() - 1)]));
    end
  endtask

  task automatic note_written(input int i);
    if (!written[i]) begin
      written[i] = 1'b1;
      written_list.push_back(i);
    end
  endtask

  // A frame opened by a clear; it stops after cut payload bytes when cut is below len.
  task automatic push_frame(input int len, input bit good_crc, input int cut);
    logic [7:0] crc;
    logic [7:0] b;
    crc = 8'd0;
    push_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
    push_byte(cur_marker);
    push_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      if (i == cut) return;
      b   = 8'($urandom_range(0, 255));
      crc = maxim_crc_next(crc, b);
      push_byte(b);
      note_written(i);
    end
    push_byte(good_crc ? crc : crc ^ 8'($urandom_range(1, 255)));
    if (good_crc) frames_made++;
  endtask

  task automatic random_chunk();
    int r;
    int len;
    int short_lim;
    r = $urandom_range(0, 99);
    short_lim = (cur_limit < 6) ? cur_limit : 6;
    if (r < 66) begin
      len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, short_lim)
                                        : $urandom_range(0, cur_limit);
      push_frame(len, $urandom_range(0, 7) != 0, len);
      repeat ($urandom_range(0, 2)) push_read();
      if ($urandom_range(0, 5) == 0) push_byte(8'($urandom_range(0, 255)));
    end else if (r < 76) begin
      push_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      push_byte(cur_marker);
      push_byte(($urandom_range(0, 1) != 0) ? 8'(cur_limit + 1)
                                            : 8'($urandom_range(cur_limit + 1, 255)));
      if ($urandom_range(0, 1) != 0) push_byte(8'($urandom_range(0, 255)));
    end else if (r < 84 || (r < 92 && cur_limit == 0)) begin
      push_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      push_byte(cur_marker ^ 8'($urandom_range(1, 255)));
    end else if (r < 92) begin
      len = $urandom_range(1, cur_limit);
      push_frame(len, 1'b1, $urandom_range(0, len - 1));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case (2'($urandom_range(0, 3)))
          KIND_READ: push_read();
          KIND_BYTE: push_byte(8'($urandom_range(0, 255)));
          KIND_CLEAR: push_item(KIND_CLEAR, 8'($urandom_range(0, 255)),
                                5'($urandom_range(0, 31)));
          default: push_item(KIND_NOP, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        endcase
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (line_q.size() != 0 || in_valid || pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] marker;
    logic [7:0] maxp;
    logic [7:0] crc;
    int         target;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset settings: unknown kind, noise, oversize length, zero
    // length with good and bad CRC, ignored bytes after the end, and a short good frame.
    push_item(KIND_NOP, 8'hFF, 5'd31);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_item(KIND_CLEAR, 8'h00, 5'd0);
    push_byte(cur_marker);
    push_byte(8'hFF);
    push_item(KIND_CLEAR, 8'hFF, 5'd31);
    push_byte(cur_marker);
    push_byte(8'd0);
    push_byte(8'd0);
    push_item(KIND_CLEAR, 8'h00, 5'd0);
    push_byte(cur_marker);
    push_byte(8'd0);
    push_byte(8'hFF);
    push_byte(8'h5A);
    push_item(KIND_CLEAR, 8'h00, 5'd0);
    crc = maxim_crc_next(maxim_crc_next(8'd0, 8'hFF), 8'h00);
    push_byte(cur_marker);
    push_byte(8'd2);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(crc);
    note_written(0);
    note_written(1);
    push_item(KIND_READ, 8'h00, 5'd0);
    push_item(KIND_READ, 8'hFF, 5'd1);
    push_item(KIND_CLEAR, 8'h00, 5'd0);
    wait_idle();

    for (int s = 0; s < 7; s++) begin
      case (s)
        0:       begin marker = 8'h00; maxp = 8'd0;  end
        1:       begin marker = 8'hFF; maxp = 8'd63; end
        2:       begin marker = START_MARKER_RST; maxp = 8'd32; end
        3:       begin marker = 8'($urandom_range(0, 255)); maxp = 8'($urandom_range(1, 31)); end
        4:       begin marker = 8'hAA; maxp = 8'd1;  end
        5:       begin marker = 8'($urandom_range(0, 255)); maxp = 8'($urandom_range(0, 255)); end
        default: begin marker = 8'($urandom_range(0, 255)); maxp = 8'd32; end
      endcase
      cfg_write(CFG_START_MARKER, marker);
      cfg_write(CFG_MAX_PAYLOAD, maxp);
      cur_marker = marker;
      cur_limit  = (maxp[5:0] < PAYLOAD_DEPTH) ? maxp[5:0] : PAYLOAD_DEPTH;
      settings_done++;
      push_frame(cur_limit, 1'b1, cur_limit);
      target = items_made + 155;
      while (items_made < target) random_chunk();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d items under the reset setting and %0d written settings,",
             items_made, settings_done);
    $display("with %0d well-formed frames; %0d results compared, %0d mismatches.",
             frames_made, results_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS framed_packet_receiver_crc8_top");
    end else begin
      $display("FAIL framed_packet_receiver_crc8_top");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("FAIL framed_packet_receiver_crc8_top");
    $finish;
  end

endmodule
